[sv/rcg_pkg.sv]
package rcg_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 64;

	localparam int KEY_W  = 32;
	localparam int LEN_W  = 7;
	localparam int COEF_W = 8;
	localparam int POS_W  = 6;
	localparam int ST_W   = 64;
	localparam int HALF_W = 32;

	localparam logic [ST_W-1:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [ST_W-1:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [ST_W-1:0] MIX_MUL_B   = 64'h94D049BB133111EB;

	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	// low bits of the second product that reach the output byte
	localparam int LOW_W = COEF_W + SHIFT_C;
	localparam int HI_W  = LOW_W - HALF_W;

	localparam logic [COEF_W-1:0] BYTE_MAX = 8'hFF;
	localparam logic [COEF_W-1:0] COEF_ONE = 8'd1;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             last;
	} tag_t;

endpackage

[sv/rcg_mix.sv]
module rcg_mix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [rcg_pkg::ST_W-1:0]   state,
	input  rcg_pkg::tag_t              in_tag,
	output logic                       out_valid,
	output logic [rcg_pkg::COEF_W-1:0] coefficient,
	output rcg_pkg::tag_t              out_tag
);
	import rcg_pkg::*;

	logic [ST_W-1:0]   w;
	logic [ST_W-1:0]   x;
	logic [ST_W-1:0]   y;
	logic [LOW_W-1:0]  z;
	logic [COEF_W-1:0] mix_byte;

	logic              v_s2, v_s3, v_s4, v_s5;
	tag_t              tag_s2, tag_s3, tag_s4, tag_s5;
	logic [ST_W-1:0]   p0_s2;
	logic [HALF_W-1:0] p1_s2, p2_s2;
	logic [LOW_W-1:0]  y_s3;
	logic [LOW_W-1:0]  q0_s4;
	logic [HI_W-1:0]   q1_s4, q2_s4;
	logic [COEF_W-1:0] coef_s5;

	// first xor-shift, split multiply by a
	assign w = state ^ (state >> SHIFT_A);

	// first product assembled, second xor-shift
	assign x = p0_s2 + {p1_s2 + p2_s2, {HALF_W{1'b0}}};
	assign y = x ^ (x >> SHIFT_B);

	// low bits of second product, final xor-shift on the byte
	assign z = q0_s4 + {q1_s4 + q2_s4, {HALF_W{1'b0}}};
	assign mix_byte = z[COEF_W-1:0] ^ z[LOW_W-1:SHIFT_C];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= in_tag;
		tag_s3 <= tag_s2;
		tag_s4 <= tag_s3;
		tag_s5 <= tag_s4;

		p0_s2 <= {{HALF_W{1'b0}}, w[HALF_W-1:0]} * {{HALF_W{1'b0}}, MIX_MUL_A[HALF_W-1:0]};
		p1_s2 <= w[ST_W-1:HALF_W] * MIX_MUL_A[HALF_W-1:0];
		p2_s2 <= w[HALF_W-1:0] * MIX_MUL_A[ST_W-1:HALF_W];

		y_s3 <= y[LOW_W-1:0];

		q0_s4 <= {{HI_W{1'b0}}, y_s3[HALF_W-1:0]} * {{HI_W{1'b0}}, MIX_MUL_B[HALF_W-1:0]};
		q1_s4 <= y_s3[LOW_W-1:HALF_W] * MIX_MUL_B[HI_W-1:0];
		q2_s4 <= y_s3[HI_W-1:0] * MIX_MUL_B[LOW_W-1:HALF_W];

		// byte mod 255 plus one
		coef_s5 <= (mix_byte == BYTE_MAX) ? COEF_ONE : mix_byte + COEF_ONE;
	end

	assign out_valid   = v_s5;
	assign coefficient = coef_s5;
	assign out_tag     = tag_s5;

endmodule

[sv/repair_coefficient_generator.sv]
// repair coefficient generator
// command channel: a word (seed, num_coefs) is taken at a rising edge
// where start is high and busy is low. num_coefs above MAX_WINDOW counts as
// MAX_WINDOW; a length of zero gives no results and leaves busy low.
// result channel: one word per window position (coefficient, position,
// last), each shown for exactly one cycle with strobe high. the receiver
// cannot hold results off, so nothing here ever stalls.
// order: each state goes from the sequencer through stage s1 and the
// mixer stages s2 to s5; one coefficient per cycle in position order.
// throughput: busy stays high while the sequencer feeds one state per
// cycle into the mixer, one per coefficient; a new command may be taken
// while the previous run still drains.
// reset clears the sequencer and every pipeline valid bit; no results are
// lost or repeated across back-to-back commands.
module repair_coefficient_generator #(
	parameter int unsigned MAX_WINDOW = rcg_pkg::MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [rcg_pkg::KEY_W-1:0]  seed,
	input  logic [rcg_pkg::LEN_W-1:0]  num_coefs,
	output logic                       strobe,
	output logic [rcg_pkg::COEF_W-1:0] coefficient,
	output logic [rcg_pkg::POS_W-1:0]  position,
	output logic                       last
);
	import rcg_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);

	logic             accept;
	logic [CNT_W-1:0] len_sat;
	logic             run_q;
	logic [CNT_W-1:0] rem_q;
	logic [POS_W-1:0] pos_q;
	logic [ST_W-1:0]  st_q;
	logic             v_s1;
	tag_t             tag_s1;
	tag_t             out_tag;

	assign accept  = start && !busy;
	assign len_sat = (num_coefs > LEN_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
		: num_coefs[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			rem_q <= '0;
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= run_q;
			if (run_q) begin
				rem_q <= rem_q - CNT_W'(1);
				pos_q <= pos_q + POS_W'(1);
				run_q <= (rem_q != CNT_W'(1));
			end else if (accept) begin
				rem_q <= len_sat;
				pos_q <= '0;
				run_q <= (len_sat != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			st_q          <= st_q + GOLDEN_STEP;
			tag_s1.position <= pos_q;
			tag_s1.last     <= (rem_q == CNT_W'(1));
		end else if (accept) begin
			st_q <= {{(ST_W - KEY_W){1'b0}}, seed};
		end
	end

	assign busy = run_q;

	rcg_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s1),
		.state       (st_q),
		.in_tag      (tag_s1),
		.out_valid   (strobe),
		.coefficient (coefficient),
		.out_tag     (out_tag)
	);

	assign position = out_tag.position;
	assign last     = out_tag.last;

endmodule
